>>> sv/psts_pkg.sv
// Shared types and constants for the power source transfer selector.
package psts_pkg;

	// Default sizes
	localparam int INPUT_COUNT_DEF = 8;
	localparam int POWER_COUNT_DEF = 4;
	localparam int WINDOW_DEF      = 256;

	// Field widths
	localparam int TIME_W   = 48;
	localparam int PCT_W    = 7;
	localparam int HOLD_W   = 16;
	localparam int STABLE_W = 20;
	localparam int LVL_W    = 8;
	localparam int QRY_W    = 3;
	localparam int RELAY_W  = 4;
	localparam int FALL_W   = 32;
	localparam int SRC_W    = 3;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 5;

	// Filter scale and the stop line
	localparam int PCT_SCALE  = 100;
	localparam int STOP_INPUT = 3;

	// Register reset values
	localparam logic [PCT_W-1:0]    LOW_PCT_RST     = 7'd30;
	localparam logic [PCT_W-1:0]    HIGH_PCT_RST    = 7'd70;
	localparam logic [HOLD_W-1:0]   HOLD_MS_RST     = 16'd1000;
	localparam logic [STABLE_W-1:0] STABLE_MS_RST   = 20'd10000;
	localparam logic [LVL_W-1:0]    INIT_LEVELS_RST = 8'd0;

	// No source connected
	localparam logic [SRC_W-1:0] SRC_NONE = 3'b111;

	// Request ops
	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_RESTART = 1'b1
	} psts_op_t;

	// Register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_LOW_PCT     = 3'd0,
		REG_HIGH_PCT    = 3'd1,
		REG_HOLD_MS     = 3'd2,
		REG_STABLE_MS   = 3'd3,
		REG_INIT_LEVELS = 3'd4
	} psts_reg_t;

endpackage

>>> sv/power_source_transfer_selector_unit.sv
// Automatic transfer switch: filtered inputs, fall tracking and source selection.
// A request passes through the input register and then the result register.
// One request per cycle unless stalled; filter, timing, selection state updates in one pass.
// Sample history lives in a WINDOW x INPUT_COUNT RAM read one slot ahead of the write pointer.
// Reset: registers to defaults, levels and windows from initial levels, no source selected;
// a fill count stands in for the window contents after reset or restart, so no clearing pass.
module power_source_transfer_selector_unit
	import psts_pkg::*;
#(
	parameter int INPUT_COUNT = INPUT_COUNT_DEF,
	parameter int POWER_COUNT = POWER_COUNT_DEF,
	parameter int WINDOW      = WINDOW_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic [TIME_W-1:0]        now_ms,
	input  logic [LVL_W-1:0]         sample_bits,
	input  logic [QRY_W-1:0]         query_index,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [LVL_W-1:0]         filtered_levels,
	output logic [RELAY_W-1:0]       relay_on,
	output logic signed [SRC_W-1:0]  selected_source,
	output logic                     stop_active,
	output logic [FALL_W-1:0]        fall_count,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	localparam int IdxW  = $clog2(WINDOW);
	localparam int CntW  = $clog2(WINDOW + 1);
	localparam int ProdW = $clog2(128 * WINDOW) + 1;
	localparam int PadW  = INPUT_COUNT + LVL_W;
	localparam logic [PadW-1:0] RstPad = PadW'(INIT_LEVELS_RST);
	localparam logic [INPUT_COUNT-1:0] RstLvl = RstPad[INPUT_COUNT-1:0];

	// Config registers
	logic [PCT_W-1:0]    low_q, high_q;
	logic [HOLD_W-1:0]   hold_q;
	logic [STABLE_W-1:0] stable_q;
	logic [LVL_W-1:0]    init_q;
	logic                cfg_wr;

	// Input stage
	logic                vld_s1;
	logic                op_s1;
	logic [TIME_W-1:0]   now_s1, lim_s1, nmh_s1;
	logic                gts_s1, gth_s1;
	logic [LVL_W-1:0]    smp_s1;
	logic [QRY_W-1:0]    qry_s1;

	// Filter and selection state
	logic [IdxW-1:0]        ptr_q, ptr_nx;
	logic [CntW-1:0]        fill_q;
	logic [INPUT_COUNT-1:0] fill_lvl_q;
	logic [INPUT_COUNT-1:0] rd_q;
	logic [INPUT_COUNT-1:0] win_mem [WINDOW];
	logic [CntW-1:0]        ones_q [INPUT_COUNT];
	logic [INPUT_COUNT-1:0] lvl_q;
	logic [TIME_W-1:0]      ft_q [INPUT_COUNT];
	logic [FALL_W-1:0]      fc_q [INPUT_COUNT];
	logic [SRC_W-1:0]       cur_q;
	logic [TIME_W-1:0]      lc_q;

	// Result register
	logic                 out_vld_q;
	logic [LVL_W-1:0]     lvl_out_q;
	logic [RELAY_W-1:0]   relay_q;
	logic [SRC_W-1:0]     src_q;
	logic                 stop_q;
	logic [FALL_W-1:0]    fc_out_q;

	// Next-state logic
	logic                   out_free, advance, do_tick, do_restart;
	logic [PadW-1:0]        smp_pad, init_pad;
	logic [INPUT_COUNT-1:0] smp_in, init_vec, old_slot;
	logic [ProdW-1:0]       thr_hi, thr_lo, scaled;
	logic [CntW-1:0]        ones_nx [INPUT_COUNT];
	logic [INPUT_COUNT-1:0] lvl_nx, ft_gt_now, ft_lt_lim;
	logic [TIME_W-1:0]      ft_nx [INPUT_COUNT];
	logic [FALL_W-1:0]      fc_nx [INPUT_COUNT];
	logic [SRC_W-1:0]       cur_nx, best;
	logic                   found, stop, sel_ok;
	logic [TIME_W-1:0]      lc_nx;
	logic [FALL_W-1:0]      fc_sel;
	logic [RELAY_W-1:0]     relay_nx;
	logic [PadW-1:0]        lvl_pad;

	// Handshake
	assign out_free = !out_vld_q || !out_stall;
	assign advance  = vld_s1 && out_free;
	assign in_stall = vld_s1 && !out_free;
	assign do_tick    = advance && (op_s1 == OP_TICK);
	assign do_restart = advance && (op_s1 == OP_RESTART);

	// Config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= LOW_PCT_RST;
			high_q   <= HIGH_PCT_RST;
			hold_q   <= HOLD_MS_RST;
			stable_q <= STABLE_MS_RST;
			init_q   <= INIT_LEVELS_RST;
		end else if (cfg_wr) begin
			case (psts_reg_t'(paddr[4:2]))
				REG_LOW_PCT:     low_q    <= pwdata[PCT_W-1:0];
				REG_HIGH_PCT:    high_q   <= pwdata[PCT_W-1:0];
				REG_HOLD_MS:     hold_q   <= pwdata[HOLD_W-1:0];
				REG_STABLE_MS:   stable_q <= pwdata[STABLE_W-1:0];
				REG_INIT_LEVELS: init_q   <= pwdata[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (psts_reg_t'(paddr[4:2]))
			REG_LOW_PCT:     prdata = DATA_W'(low_q);
			REG_HIGH_PCT:    prdata = DATA_W'(high_q);
			REG_HOLD_MS:     prdata = DATA_W'(hold_q);
			REG_STABLE_MS:   prdata = DATA_W'(stable_q);
			REG_INIT_LEVELS: prdata = DATA_W'(init_q);
			default:         prdata = '0;
		endcase
	end

	// Input register; time thresholds are worked out here, off the state loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= op;
			now_s1 <= now_ms;
			smp_s1 <= sample_bits;
			qry_s1 <= query_index;
			lim_s1 <= now_ms - TIME_W'(stable_q);
			gts_s1 <= now_ms > TIME_W'(stable_q);
			nmh_s1 <= now_ms - TIME_W'(hold_q);
			gth_s1 <= now_ms > TIME_W'(hold_q);
		end
	end

	// Sample window RAM: write the current slot, prefetch the next one
	assign ptr_nx = (ptr_q == IdxW'(WINDOW - 1)) ? '0 : ptr_q + IdxW'(1);

	always_ff @(posedge clk) begin
		if (do_tick) begin
			win_mem[ptr_q] <= smp_in;
			rd_q           <= win_mem[ptr_nx];
		end
	end

	// Filter, fall tracking and source selection
	always_comb begin
		smp_pad  = {{INPUT_COUNT{1'b0}}, smp_s1};
		smp_in   = smp_pad[INPUT_COUNT-1:0];
		init_pad = {{INPUT_COUNT{1'b0}}, init_q};
		init_vec = init_pad[INPUT_COUNT-1:0];
		old_slot = (fill_q == CntW'(WINDOW)) ? rd_q : fill_lvl_q;
		// pct > high  <=>  ones*100 >= (high+1)*W ; pct < low  <=>  ones*100 < low*W
		thr_hi = ProdW'({1'b0, high_q} + 8'd1) * ProdW'(WINDOW);
		thr_lo = ProdW'(low_q) * ProdW'(WINDOW);
		scaled = '0;
		lvl_nx = lvl_q;
		for (int i = 0; i < INPUT_COUNT; i++) begin
			ones_nx[i]   = ones_q[i] + CntW'(smp_in[i]) - CntW'(old_slot[i]);
			scaled       = ProdW'(ones_nx[i]) * ProdW'(PCT_SCALE);
			ft_gt_now[i] = ft_q[i] > now_s1;
			ft_lt_lim[i] = ft_q[i] < lim_s1;
			ft_nx[i]     = ft_gt_now[i] ? '0 : ft_q[i];
			fc_nx[i]     = fc_q[i];
			if (!lvl_q[i]) begin
				if (scaled >= thr_hi) lvl_nx[i] = 1'b1;
			end else if (scaled < thr_lo) begin
				lvl_nx[i] = 1'b0;
				ft_nx[i]  = now_s1;
				if (fc_q[i] != '1) fc_nx[i] = fc_q[i] + FALL_W'(1);
			end
		end
		stop = lvl_nx[STOP_INPUT];

		// first power input that has been up long enough
		best  = SRC_NONE;
		found = 1'b0;
		for (int i = 0; i < POWER_COUNT; i++) begin
			if (!stop && !lvl_nx[i]) ft_nx[i] = now_s1;
			if (!found && lvl_nx[i] && (ft_gt_now[i] || ft_lt_lim[i])) begin
				best  = SRC_W'(i);
				found = 1'b1;
			end
		end

		// break-before-make with hold interval
		sel_ok = gts_s1 && gth_s1 && (lc_q < nmh_s1);
		cur_nx = cur_q;
		lc_nx  = lc_q;
		if (stop) begin
			cur_nx = SRC_NONE;
			lc_nx  = now_s1;
		end else begin
			if (lc_q > now_s1) lc_nx = now_s1;
			if (sel_ok && (best != cur_q)) begin
				cur_nx = (cur_q != SRC_NONE) ? SRC_NONE : best;
				lc_nx  = now_s1;
			end
		end

		// restart reloads filters and drops relays
		if (op_s1 == OP_RESTART) begin
			lvl_nx = init_vec;
			cur_nx = SRC_NONE;
			lc_nx  = lc_q;
			for (int i = 0; i < INPUT_COUNT; i++) begin
				ones_nx[i] = init_vec[i] ? CntW'(WINDOW) : '0;
				ft_nx[i]   = '0;
				fc_nx[i]   = '0;
			end
		end

		fc_sel = '0;
		for (int i = 0; i < INPUT_COUNT; i++) begin
			if (int'(qry_s1) == i) fc_sel = fc_nx[i];
		end
		for (int i = 0; i < RELAY_W; i++) begin
			relay_nx[i] = (cur_nx == SRC_W'(i));
		end
		lvl_pad = {{LVL_W{1'b0}}, lvl_nx};
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			fill_q     <= '0;
			fill_lvl_q <= RstLvl;
			lvl_q      <= RstLvl;
			cur_q      <= SRC_NONE;
			lc_q       <= '0;
			for (int i = 0; i < INPUT_COUNT; i++) begin
				ones_q[i] <= RstLvl[i] ? CntW'(WINDOW) : '0;
				ft_q[i]   <= '0;
				fc_q[i]   <= '0;
			end
		end else if (advance) begin
			lvl_q <= lvl_nx;
			cur_q <= cur_nx;
			lc_q  <= lc_nx;
			for (int i = 0; i < INPUT_COUNT; i++) begin
				ones_q[i] <= ones_nx[i];
				ft_q[i]   <= ft_nx[i];
				fc_q[i]   <= fc_nx[i];
			end
			if (do_restart) begin
				fill_q     <= '0;
				fill_lvl_q <= init_vec;
			end else begin
				ptr_q <= ptr_nx;
				if (fill_q != CntW'(WINDOW)) fill_q <= fill_q + CntW'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lvl_out_q <= lvl_pad[LVL_W-1:0];
			relay_q   <= relay_nx;
			src_q     <= cur_nx;
			stop_q    <= stop && (op_s1 == OP_TICK) || (op_s1 == OP_RESTART) && init_vec[STOP_INPUT];
			fc_out_q  <= fc_sel;
		end
	end

	assign out_valid       = out_vld_q;
	assign filtered_levels = lvl_out_q;
	assign relay_on        = relay_q;
	assign selected_source = $signed(src_q);
	assign stop_active     = stop_q;
	assign fall_count      = fc_out_q;

	// Checks
	a_relay_matches_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((relay_on == '0) == ($unsigned(selected_source) == SRC_NONE)))
		else $error("relay mask disagrees with selected source");

	a_stop_drops_relays: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stop_active |-> (relay_on == '0))
		else $error("relay on while stop line is active");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(WINDOW))
		else $error("window fill count past window depth");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("request stalled without a blocked result");

endmodule

>>> tb/sv/tb_power_source_transfer_selector_unit.sv
// Testbench for the power source transfer selector: predicted status per request, checked in order.
module tb_power_source_transfer_selector_unit;
	import psts_pkg::*;

	localparam int INPUTS  = INPUT_COUNT_DEF;
	localparam int SOURCES = POWER_COUNT_DEF;
	localparam int DEPTH   = WINDOW_DEF;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// One status word as the block reports it
	typedef struct packed {
		logic [LVL_W-1:0]   levels;
		logic [RELAY_W-1:0] relays;
		logic [SRC_W-1:0]   source;
		logic               stop;
		logic [FALL_W-1:0]  falls;
	} ats_status_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    op = OP_TICK;
	logic [TIME_W-1:0]       now_ms = '0;
	logic [LVL_W-1:0]        sample_bits = '0;
	logic [QRY_W-1:0]        query_index = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [LVL_W-1:0]        filtered_levels;
	logic [RELAY_W-1:0]      relay_on;
	logic signed [SRC_W-1:0] selected_source;
	logic                    stop_active;
	logic [FALL_W-1:0]       fall_count;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [ADDR_W-1:0]       paddr = '0;
	logic [DATA_W-1:0]       pwdata = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;

	// Shadow registers
	logic [PCT_W-1:0]    low_pct = LOW_PCT_RST;
	logic [PCT_W-1:0]    high_pct = HIGH_PCT_RST;
	logic [HOLD_W-1:0]   hold_ms = HOLD_MS_RST;
	logic [STABLE_W-1:0] stable_ms = STABLE_MS_RST;
	logic [LVL_W-1:0]    init_lvls = INIT_LEVELS_RST;

	// Predicted filter and switch state
	logic [LVL_W-1:0]           hist [DEPTH];
	logic [$clog2(DEPTH)-1:0]   hist_ptr = '0;
	int unsigned                ones [INPUTS];
	logic [LVL_W-1:0]           lvl;
	logic [TIME_W-1:0]          fall_stamp [INPUTS];
	logic [FALL_W-1:0]          fall_tally [INPUTS];
	int                         cur_src;
	logic [TIME_W-1:0]          last_switch = '0;

	ats_status_t       status_q [$];
	int                errors = 0;
	bit                calm = 1'b0;
	logic [TIME_W-1:0] clock_ms = '0;

	power_source_transfer_selector_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Windows, levels and fall tracking back to the initial levels, and no source selected
	function automatic void reload_filters();
		lvl = init_lvls;
		for (int i = 0; i < INPUTS; i++) begin
			ones[i] = init_lvls[i] ? DEPTH : 0;
			fall_stamp[i] = '0;
			fall_tally[i] = '0;
		end
		for (int j = 0; j < DEPTH; j++)
			hist[j] = init_lvls;
		cur_src = -1;
	endfunction

	// Advance the predicted state by one request and return the status it yields
	function automatic ats_status_t predict_status(psts_op_t kind, logic [TIME_W-1:0] now,
			logic [LVL_W-1:0] bits, logic [QRY_W-1:0] q);
		logic [LVL_W-1:0]  oldest;
		logic [TIME_W-1:0] limit;
		int unsigned       pct;
		int                pick;
		ats_status_t       st;
		if (kind == OP_RESTART) begin
			reload_filters();
		end else begin
			oldest = hist[hist_ptr];
			for (int i = 0; i < INPUTS; i++) begin
				ones[i] = ones[i] - oldest[i] + bits[i];
				if (fall_stamp[i] > now)
					fall_stamp[i] = '0;
				pct = ones[i] * PCT_SCALE / DEPTH;
				if (!lvl[i]) begin
					if (pct > high_pct)
						lvl[i] = 1'b1;
				end else if (pct < low_pct) begin
					if (fall_tally[i] != '1)
						fall_tally[i]++;
					lvl[i] = 1'b0;
					fall_stamp[i] = now;
				end
			end
			hist[hist_ptr] = bits;
			hist_ptr++;
			// stop line drops everything
			if (lvl[STOP_INPUT]) begin
				cur_src = -1;
				last_switch = now;
			end else begin
				for (int i = 0; i < SOURCES; i++)
					if (!lvl[i])
						fall_stamp[i] = now;
				if (last_switch > now)
					last_switch = now;
				if (now > TIME_W'(stable_ms) && now - last_switch > TIME_W'(hold_ms)) begin
					limit = now - TIME_W'(stable_ms);
					pick = -1;
					for (int i = SOURCES - 1; i >= 0; i--)
						if (fall_stamp[i] < limit)
							pick = i;
					// break before make
					if (pick != cur_src) begin
						cur_src = (cur_src != -1) ? -1 : pick;
						last_switch = now;
					end
				end
			end
		end
		st.levels = lvl;
		st.relays = (cur_src >= 0) ? RELAY_W'(1) << cur_src : '0;
		st.source = SRC_W'(cur_src);
		st.stop   = lvl[STOP_INPUT];
		st.falls  = fall_tally[q];
		return st;
	endfunction

	// Receiver stall
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 22);

	task automatic check_field(string name, logic [FALL_W-1:0] want, logic [FALL_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Compare each delivered status with the oldest prediction
	always @(posedge clk) begin
		ats_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (status_q.size() == 0) begin
				$error("status delivered with none pending");
				errors++;
			end else begin
				want = status_q.pop_front();
				check_field("filtered_levels", FALL_W'(want.levels), FALL_W'(filtered_levels));
				check_field("relay_on", FALL_W'(want.relays), FALL_W'(relay_on));
				check_field("selected_source", FALL_W'(want.source),
					FALL_W'($unsigned(selected_source)));
				check_field("stop_active", FALL_W'(want.stop), FALL_W'(stop_active));
				check_field("fall_count", want.falls, fall_count);
			end
		end
	end

	// Send one request, with a random gap and now and then a full drain first
	task automatic send_request(psts_op_t kind, logic [TIME_W-1:0] now, logic [LVL_W-1:0] bits,
			logic [QRY_W-1:0] q);
		bit gap;
		bit wait_out;
		gap = !calm && ($urandom_range(99) < 22);
		wait_out = ($urandom_range(249) == 0);
		if (gap || wait_out) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (wait_out && status_q.size() != 0)
				@(posedge clk);
			while (!calm && $urandom_range(99) < 22)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		now_ms <= now;
		sample_bits <= bits;
		query_index <= q;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		status_q.push_back(predict_status(kind, now, bits, q));
	endtask

	// Stop sending and let every pending status come out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(psts_reg_t idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LOW_PCT:     low_pct = value[PCT_W-1:0];
			REG_HIGH_PCT:    high_pct = value[PCT_W-1:0];
			REG_HOLD_MS:     hold_ms = value[HOLD_W-1:0];
			REG_STABLE_MS:   stable_ms = value[STABLE_W-1:0];
			REG_INIT_LEVELS: init_lvls = value[LVL_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(logic [PCT_W-1:0] lo, logic [PCT_W-1:0] hi, logic [HOLD_W-1:0] hold,
			logic [STABLE_W-1:0] stable, logic [LVL_W-1:0] init);
		settle();
		write_reg(REG_LOW_PCT, DATA_W'(lo));
		write_reg(REG_HIGH_PCT, DATA_W'(hi));
		write_reg(REG_HOLD_MS, DATA_W'(hold));
		write_reg(REG_STABLE_MS, DATA_W'(stable));
		write_reg(REG_INIT_LEVELS, DATA_W'(init));
	endtask

	// Random sample runs: a held pattern with sparse noise, time mostly moving forward
	task automatic run_traffic(int count, int run_len, int step_max, int stop_odds);
		logic [LVL_W-1:0]  pattern;
		logic [LVL_W-1:0]  bits;
		logic [TIME_W-1:0] back;
		int                roll;
		psts_op_t          kind;
		pattern = LVL_W'($urandom);
		pattern[STOP_INPUT] = ($urandom_range(stop_odds) == 0);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(run_len - 1) == 0) begin
				pattern = LVL_W'($urandom);
				pattern[STOP_INPUT] = ($urandom_range(stop_odds) == 0);
			end
			bits = pattern;
			if ($urandom_range(7) == 0)
				bits[$urandom_range(LVL_W - 1)] ^= 1'b1;
			roll = $urandom_range(299);
			if (roll == 0) begin
				clock_ms = TIME_W'({$urandom, $urandom});
			end else if (roll < 5) begin
				// step back in time so stored fall times lie ahead
				back = TIME_W'($urandom_range(20000));
				clock_ms = (clock_ms > back) ? clock_ms - back : '0;
			end else begin
				clock_ms += TIME_W'($urandom_range(step_max));
			end
			kind = ($urandom_range(99) == 0) ? OP_RESTART : OP_TICK;
			send_request(kind, clock_ms, bits, QRY_W'($urandom));
		end
	endtask

	// Field extremes under the reset settings
	task automatic test_field_extremes();
		send_request(OP_TICK, '0, 8'h00, 3'd0);
		send_request(OP_TICK, TIME_MAX, 8'hFF, 3'd7);
		send_request(OP_RESTART, '0, 8'h00, 3'd3);
		send_request(OP_TICK, 48'h5555_5555_5555, 8'hAA, 3'd5);
		send_request(OP_TICK, 48'hAAAA_AAAA_AAAA, 8'h55, 3'd2);
		send_request(OP_TICK, 48'd1, 8'hFF, 3'd1);
		send_request(OP_TICK, 48'd2, 8'hFF, 3'd4);
		send_request(OP_TICK, 48'd3, 8'h00, 3'd6);
	endtask

	// Selection, stop line, restart, time going backward, percent above 100
	task automatic test_transfer_sequence();
		configure(7'd0, 7'd0, 16'd0, 20'd0, 8'h00);
		// inputs 0..2 rise after three ones, input 0 then gets connected
		send_request(OP_TICK, 48'd100, 8'h07, 3'd0);
		send_request(OP_TICK, 48'd110, 8'h07, 3'd1);
		send_request(OP_TICK, 48'd120, 8'h07, 3'd2);
		send_request(OP_TICK, 48'd130, 8'h07, 3'd0);
		// stop line comes up and drops the relay
		send_request(OP_TICK, 48'd140, 8'h0F, 3'd3);
		send_request(OP_TICK, 48'd150, 8'h0F, 3'd3);
		send_request(OP_TICK, 48'd160, 8'h0F, 3'd3);
		send_request(OP_RESTART, 48'd170, 8'h00, 3'd0);
		// time runs backward
		send_request(OP_TICK, 48'd60, 8'h07, 3'd1);
		send_request(OP_TICK, 48'd50, 8'h07, 3'd2);
		send_request(OP_TICK, 48'd55, 8'h07, 3'd0);
		// restart into all-high levels, then everything falls
		configure(7'd100, 7'd127, 16'd0, 20'd0, 8'hFF);
		send_request(OP_RESTART, 48'd200, 8'h00, 3'd3);
		send_request(OP_TICK, 48'd210, 8'h00, 3'd0);
		send_request(OP_TICK, 48'd220, 8'hFF, 3'd3);
		send_request(OP_TICK, 48'd230, 8'hFF, 3'd7);
	endtask

	task automatic test_default_filter();
		configure(LOW_PCT_RST, HIGH_PCT_RST, HOLD_MS_RST, STABLE_MS_RST, 8'h00);
		clock_ms = '0;
		run_traffic(350, 220, 120, 5);
	endtask

	task automatic test_open_thresholds();
		configure(7'd0, 7'd0, 16'd0, 20'd0, 8'hFF);
		run_traffic(150, 20, 40, 3);
	endtask

	task automatic test_closed_thresholds();
		configure(7'd100, 7'd100, 16'hFFFF, 20'hFFFFF, 8'h55);
		run_traffic(150, 30, 20000, 4);
	endtask

	task automatic test_wide_percent();
		configure(7'd127, 7'd0, 16'd16, 20'd300, 8'hA7);
		run_traffic(100, 10, 30, 4);
	endtask

	task automatic test_random_settings();
		logic [PCT_W-1:0] lo;
		logic [PCT_W-1:0] hi;
		for (int r = 0; r < 3; r++) begin
			lo = PCT_W'($urandom_range(50, 10));
			hi = PCT_W'($urandom_range(95, 50));
			configure(lo, hi, HOLD_W'($urandom_range(3000)), STABLE_W'($urandom_range(20000)),
				LVL_W'($urandom));
			// first round runs with no receiver stalls and no random gaps, only an occasional full drain
			calm = (r == 0);
			run_traffic(120, 150, 80, 6);
		end
		calm = 1'b0;
	endtask

	initial begin
		reload_filters();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_transfer_sequence();
		test_default_filter();
		test_open_thresholds();
		test_closed_thresholds();
		test_wide_percent();
		test_random_settings();
		settle();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
